>>> hdl/rvx_pkg.sv
package rvx_pkg;

  typedef enum logic [3:0] {
    OP_LUI,
    OP_AUIPC,
    OP_JAL,
    OP_JALR,
    OP_BRANCH,
    OP_LOAD,
    OP_STORE,
    OP_ALU,
    OP_MUL,
    OP_DIV,
    OP_EBREAK,
    OP_INVALID
  } op_e;

  typedef enum logic [3:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_SLL,
    ALU_SLTU,
    ALU_XOR,
    ALU_OR,
    ALU_AND,
    ALU_SRL,
    ALU_SRA
  } alu_e;

  typedef struct packed {
    op_e         op;
    alu_e        fn;
    logic        b_imm;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
  } uop_t;

  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  localparam logic [2:0] F3_JALR = 3'd0;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_SB  = 3'd0;
  localparam logic [2:0] F3_SH  = 3'd1;
  localparam logic [2:0] F3_SW  = 3'd2;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_MUL  = 3'd0;
  localparam logic [2:0] F3_DIV  = 3'd4;
  localparam logic [2:0] F3_DIVU = 3'd5;
  localparam logic [2:0] F3_REM  = 3'd6;

  localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;
  localparam logic [4:0]  REG_A0      = 5'd10;
  localparam logic [31:0] INSN_LEN    = 32'd4;
  localparam logic [31:0] RESET_PC    = 32'h8000_0000;

  localparam logic [1:0] ST_RUN     = 2'd0;
  localparam logic [1:0] ST_EBREAK  = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_HALTED  = 2'd3;

endpackage

>>> hdl/rvx_decode.sv
module rvx_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [31:0]       instruction_i,
  output logic              full_o,
  output rvx_pkg::uop_t     uop_o,
  output logic              uop_vld_o,
  input  logic              uop_pop_i
);

  localparam int QDEPTH = 2;
  localparam int CW     = $clog2(QDEPTH + 1);

  rvx_pkg::uop_t dec;
  rvx_pkg::uop_t fifo_q [QDEPTH];
  logic [CW-1:0] count_q;
  logic          wptr_q;
  logic          rptr_q;
  logic          do_push;
  logic          do_pop;

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] imm_u;

  assign opc   = instruction_i[6:0];
  assign f3    = instruction_i[14:12];
  assign f7    = instruction_i[31:25];
  assign imm_i = {{20{instruction_i[31]}}, instruction_i[31:20]};
  assign imm_s = {{20{instruction_i[31]}}, instruction_i[31:25], instruction_i[11:7]};
  assign imm_b = {{19{instruction_i[31]}}, instruction_i[31], instruction_i[7],
                  instruction_i[30:25], instruction_i[11:8], 1'b0};
  assign imm_j = {{11{instruction_i[31]}}, instruction_i[31], instruction_i[19:12],
                  instruction_i[20], instruction_i[30:21], 1'b0};
  assign imm_u = {instruction_i[31:12], 12'b0};

  always_comb begin
    dec       = '0;
    dec.op    = rvx_pkg::OP_INVALID;
    dec.fn    = rvx_pkg::ALU_ADD;
    dec.f3    = f3;
    dec.rd    = instruction_i[11:7];
    dec.rs1   = instruction_i[19:15];
    dec.rs2   = instruction_i[24:20];
    dec.imm   = imm_i;
    unique case (opc)
      rvx_pkg::OPC_LUI: begin
        dec.op  = rvx_pkg::OP_LUI;
        dec.imm = imm_u;
      end
      rvx_pkg::OPC_AUIPC: begin
        dec.op  = rvx_pkg::OP_AUIPC;
        dec.imm = imm_u;
      end
      rvx_pkg::OPC_JAL: begin
        dec.op  = rvx_pkg::OP_JAL;
        dec.imm = imm_j;
      end
      rvx_pkg::OPC_JALR: begin
        if (f3 == rvx_pkg::F3_JALR) dec.op = rvx_pkg::OP_JALR;
      end
      rvx_pkg::OPC_BRANCH: begin
        dec.imm = imm_b;
        case (f3) inside
          rvx_pkg::F3_BEQ, rvx_pkg::F3_BNE, rvx_pkg::F3_BLT, rvx_pkg::F3_BGE,
          rvx_pkg::F3_BLTU, rvx_pkg::F3_BGEU: dec.op = rvx_pkg::OP_BRANCH;
          default: dec.op = rvx_pkg::OP_INVALID;
        endcase
      end
      rvx_pkg::OPC_LOAD: begin
        case (f3) inside
          rvx_pkg::F3_LW, rvx_pkg::F3_LH, rvx_pkg::F3_LBU: dec.op = rvx_pkg::OP_LOAD;
          default: dec.op = rvx_pkg::OP_INVALID;
        endcase
      end
      rvx_pkg::OPC_STORE: begin
        dec.imm = imm_s;
        case (f3) inside
          rvx_pkg::F3_SB, rvx_pkg::F3_SH, rvx_pkg::F3_SW: dec.op = rvx_pkg::OP_STORE;
          default: dec.op = rvx_pkg::OP_INVALID;
        endcase
      end
      rvx_pkg::OPC_OPIMM: begin
        dec.b_imm = 1'b1;
        dec.op    = rvx_pkg::OP_ALU;
        unique case (f3)
          rvx_pkg::F3_ADD:  dec.fn = rvx_pkg::ALU_ADD;
          rvx_pkg::F3_SLTU: dec.fn = rvx_pkg::ALU_SLTU;
          rvx_pkg::F3_XOR:  dec.fn = rvx_pkg::ALU_XOR;
          rvx_pkg::F3_OR:   dec.fn = rvx_pkg::ALU_OR;
          rvx_pkg::F3_AND:  dec.fn = rvx_pkg::ALU_AND;
          rvx_pkg::F3_SLL: begin
            dec.fn = rvx_pkg::ALU_SLL;
            if (f7 != rvx_pkg::F7_BASE) dec.op = rvx_pkg::OP_INVALID;
          end
          rvx_pkg::F3_SR: begin
            if (f7 == rvx_pkg::F7_BASE) dec.fn = rvx_pkg::ALU_SRL;
            else if (f7 == rvx_pkg::F7_ALT) dec.fn = rvx_pkg::ALU_SRA;
            else dec.op = rvx_pkg::OP_INVALID;
          end
          default: dec.op = rvx_pkg::OP_INVALID;
        endcase
      end
      rvx_pkg::OPC_OP: begin
        dec.op = rvx_pkg::OP_ALU;
        if (f7 == rvx_pkg::F7_BASE) begin
          unique case (f3)
            rvx_pkg::F3_ADD:  dec.fn = rvx_pkg::ALU_ADD;
            rvx_pkg::F3_SLL:  dec.fn = rvx_pkg::ALU_SLL;
            rvx_pkg::F3_SLTU: dec.fn = rvx_pkg::ALU_SLTU;
            rvx_pkg::F3_XOR:  dec.fn = rvx_pkg::ALU_XOR;
            rvx_pkg::F3_OR:   dec.fn = rvx_pkg::ALU_OR;
            rvx_pkg::F3_AND:  dec.fn = rvx_pkg::ALU_AND;
            default:          dec.op = rvx_pkg::OP_INVALID;
          endcase
        end else if (f7 == rvx_pkg::F7_ALT) begin
          unique case (f3)
            rvx_pkg::F3_ADD: dec.fn = rvx_pkg::ALU_SUB;
            rvx_pkg::F3_SR:  dec.fn = rvx_pkg::ALU_SRA;
            default:         dec.op = rvx_pkg::OP_INVALID;
          endcase
        end else if (f7 == rvx_pkg::F7_MULDIV) begin
          case (f3) inside
            rvx_pkg::F3_MUL: dec.op = rvx_pkg::OP_MUL;
            rvx_pkg::F3_DIV, rvx_pkg::F3_DIVU, rvx_pkg::F3_REM: dec.op = rvx_pkg::OP_DIV;
            default: dec.op = rvx_pkg::OP_INVALID;
          endcase
        end else begin
          dec.op = rvx_pkg::OP_INVALID;
        end
      end
      rvx_pkg::OPC_SYSTEM: begin
        if (instruction_i == rvx_pkg::EBREAK_WORD) begin
          // The back end reads a0 through the first source port.
          dec.op  = rvx_pkg::OP_EBREAK;
          dec.rs1 = rvx_pkg::REG_A0;
        end
      end
      default: dec.op = rvx_pkg::OP_INVALID;
    endcase
  end

  assign full_o    = (count_q == CW'(QDEPTH));
  assign uop_vld_o = (count_q != '0);
  assign uop_o     = fifo_q[rptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = uop_pop_i && uop_vld_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
    end else begin
      if (do_push) wptr_q <= !wptr_q;
      if (do_pop) rptr_q <= !rptr_q;
      if (do_push && !do_pop) count_q <= count_q + CW'(1);
      else if (do_pop && !do_push) count_q <= count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) fifo_q[wptr_q] <= dec;
  end

endmodule

>>> hdl/rvx_exec.sv
module rvx_exec #(
  parameter int MEM_BYTES = 65536
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i,
  input  rvx_pkg::uop_t     uop_i,
  input  logic              uop_vld_i,
  output logic              uop_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [31:0]       this_pc_o,
  output logic [31:0]       next_pc_o,
  output logic              reg_written_o,
  output logic [4:0]        reg_index_o,
  output logic [31:0]       reg_value_o,
  output logic [1:0]        status_o,
  output logic [31:0]       halt_code_o
);

  localparam int         AW     = $clog2(MEM_BYTES);
  localparam bit         POW2   = (MEM_BYTES == (1 << AW));
  localparam logic [AW:0] MEM_SZ = (AW + 1)'(MEM_BYTES);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(MEM_BYTES));

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_AMOD = 3'd2;
  localparam logic [2:0] S_MEM  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DFIX = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]  state_q;
  logic [31:0] pc_q;
  logic        halted_q;
  logic        out_vld_q;
  logic [4:0]  cnt_q;
  logic [31:0] rf_q [32];
  logic [31:0] rf_vld_q;
  logic [31:0] a_raw_q;
  logic [31:0] b_raw_q;
  logic [7:0]  dmem_q [MEM_BYTES];
  logic [7:0]  mrd_q;

  rvx_pkg::uop_t uop_q;
  logic [31:0] val_q;
  logic [31:0] npc_q;
  logic        wr_q;
  logic [1:0]  st_q;
  logic [31:0] code_q;
  logic [31:0] addr_q;
  logic [AW-1:0] idx_q;
  logic [AW:0] rmod_q;
  logic [63:0] rprod_q;
  logic [31:0] dvd_q;
  logic [32:0] rem_q;
  logic [31:0] dvs_q;
  logic        negq_q;
  logic        negr_q;

  logic [31:0] this_pc_q;
  logic [31:0] next_pc_q;
  logic        reg_written_q;
  logic [4:0]  reg_index_q;
  logic [31:0] reg_value_q;
  logic [1:0]  status_q;
  logic [31:0] halt_code_q;

  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] opb;
  logic [31:0] alu;
  logic        take;
  logic [31:0] maddr;
  logic [2:0]  nbytes;
  logic        is_load;
  logic        fire;
  logic        rf_we;
  logic        mem_we;
  logic        mem_act;
  logic [7:0]  mem_wd;
  logic [AW-1:0] idx_d;
  logic [AW:0] idx_inc;
  logic [31:0] rest;
  logic [AW:0] rmod_d;
  logic [32:0] rtry_d;
  logic [31:0] asm_val;
  logic        div_signed;
  logic        div_rem;

  assign a          = rf_vld_q[uop_q.rs1] ? a_raw_q : 32'd0;
  assign b          = rf_vld_q[uop_q.rs2] ? b_raw_q : 32'd0;
  assign opb        = uop_q.b_imm ? uop_q.imm : b;
  assign maddr      = a + uop_q.imm;
  assign is_load    = (uop_q.op == rvx_pkg::OP_LOAD);
  assign div_signed = (uop_q.f3 != rvx_pkg::F3_DIVU);
  assign div_rem    = (uop_q.f3 == rvx_pkg::F3_REM);

  always_comb begin
    unique case (uop_q.fn)
      rvx_pkg::ALU_ADD:  alu = a + opb;
      rvx_pkg::ALU_SUB:  alu = a - opb;
      rvx_pkg::ALU_SLL:  alu = a << opb[4:0];
      rvx_pkg::ALU_SLTU: alu = {31'd0, a < opb};
      rvx_pkg::ALU_XOR:  alu = a ^ opb;
      rvx_pkg::ALU_OR:   alu = a | opb;
      rvx_pkg::ALU_AND:  alu = a & opb;
      rvx_pkg::ALU_SRL:  alu = a >> opb[4:0];
      rvx_pkg::ALU_SRA:  alu = 32'($signed(a) >>> opb[4:0]);
      default:           alu = 32'd0;
    endcase
  end

  always_comb begin
    unique case (uop_q.f3)
      rvx_pkg::F3_BEQ:  take = (a == b);
      rvx_pkg::F3_BNE:  take = (a != b);
      rvx_pkg::F3_BLT:  take = ($signed(a) < $signed(b));
      rvx_pkg::F3_BGE:  take = !($signed(a) < $signed(b));
      rvx_pkg::F3_BLTU: take = (a < b);
      rvx_pkg::F3_BGEU: take = (a >= b);
      default:          take = 1'b0;
    endcase
  end

  // Loads and stores share the size coding of funct3 except for lbu.
  always_comb begin
    case (uop_q.f3) inside
      rvx_pkg::F3_SW:          nbytes = 3'd4;
      rvx_pkg::F3_SH:          nbytes = 3'd2;
      default:                 nbytes = 3'd1;
    endcase
  end

  assign idx_inc = {1'b0, idx_q} + (AW + 1)'(1);
  assign idx_d   = (idx_inc == MEM_SZ) ? '0 : idx_inc[AW-1:0];
  assign rest    = addr_q - rprod_q[63:32] * 32'(MEM_BYTES);
  assign rmod_d  = (rmod_q >= MEM_SZ) ? (rmod_q - MEM_SZ) : rmod_q;
  assign rtry_d  = {rem_q[31:0], dvd_q[31]};
  assign asm_val = val_q | (32'({24'd0, mrd_q}) << {cnt_q - 5'd1, 3'b000});

  assign mem_act = (state_q == S_MEM) && (cnt_q < {2'b00, nbytes});
  assign mem_we  = mem_act && !is_load;
  assign mem_wd  = 8'(b >> {cnt_q, 3'b000});
  assign fire    = (state_q == S_DONE) && (!out_vld_q || pop_i);
  assign rf_we   = fire && wr_q && (uop_q.rd != 5'd0);
  assign uop_pop_o = (state_q == S_IDLE) && uop_vld_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pc_q      <= rvx_pkg::RESET_PC;
      halted_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
      rf_vld_q  <= '0;
    end else begin
      if (fire) out_vld_q <= 1'b1;
      else if (pop_i) out_vld_q <= 1'b0;
      if (rf_we) rf_vld_q[uop_q.rd] <= 1'b1;
      unique case (state_q)
        S_IDLE: begin
          if (uop_vld_i) state_q <= S_EXEC;
        end
        S_EXEC: begin
          cnt_q <= '0;
          if (halted_q) state_q <= S_DONE;
          else if (uop_q.op == rvx_pkg::OP_LOAD || uop_q.op == rvx_pkg::OP_STORE)
            state_q <= POW2 ? S_MEM : S_AMOD;
          else if (uop_q.op == rvx_pkg::OP_DIV && b != 32'd0 &&
                   !(div_signed && a == 32'h8000_0000 && b == 32'hFFFF_FFFF))
            state_q <= S_DIV;
          else state_q <= S_DONE;
        end
        S_AMOD: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd2) begin
            cnt_q   <= '0;
            state_q <= S_MEM;
          end
        end
        S_MEM: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == {2'b00, nbytes}) state_q <= S_DONE;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) state_q <= S_DFIX;
        end
        S_DFIX: state_q <= S_DONE;
        S_DONE: begin
          if (fire) begin
            pc_q    <= npc_q;
            state_q <= S_IDLE;
            if (st_q != rvx_pkg::ST_RUN) halted_q <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (cfg_we_i) pc_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (uop_vld_i) uop_q <= uop_i;
      end
      S_EXEC: begin
        val_q  <= 32'd0;
        npc_q  <= pc_q + rvx_pkg::INSN_LEN;
        wr_q   <= 1'b0;
        st_q   <= rvx_pkg::ST_RUN;
        code_q <= 32'd0;
        if (halted_q) begin
          npc_q <= pc_q;
          st_q  <= rvx_pkg::ST_HALTED;
        end else begin
          unique case (uop_q.op)
            rvx_pkg::OP_LUI: begin
              val_q <= uop_q.imm;
              wr_q  <= 1'b1;
            end
            rvx_pkg::OP_AUIPC: begin
              val_q <= pc_q + uop_q.imm;
              wr_q  <= 1'b1;
            end
            rvx_pkg::OP_JAL: begin
              val_q <= pc_q + rvx_pkg::INSN_LEN;
              npc_q <= pc_q + uop_q.imm;
              wr_q  <= 1'b1;
            end
            rvx_pkg::OP_JALR: begin
              val_q <= pc_q + rvx_pkg::INSN_LEN;
              npc_q <= maddr & ~32'd1;
              wr_q  <= 1'b1;
            end
            rvx_pkg::OP_BRANCH: begin
              if (take) npc_q <= pc_q + uop_q.imm;
            end
            rvx_pkg::OP_LOAD: begin
              wr_q   <= 1'b1;
              addr_q <= maddr;
              idx_q  <= maddr[AW-1:0];
              rmod_q <= '0;
            end
            rvx_pkg::OP_STORE: begin
              addr_q <= maddr;
              idx_q  <= maddr[AW-1:0];
              rmod_q <= '0;
            end
            rvx_pkg::OP_ALU: begin
              val_q <= alu;
              wr_q  <= 1'b1;
            end
            rvx_pkg::OP_MUL: begin
              val_q <= a * b;
              wr_q  <= 1'b1;
            end
            rvx_pkg::OP_DIV: begin
              wr_q   <= 1'b1;
              rem_q  <= '0;
              dvd_q  <= (div_signed && a[31]) ? (32'd0 - a) : a;
              dvs_q  <= (div_signed && b[31]) ? (32'd0 - b) : b;
              negq_q <= div_signed && (a[31] ^ b[31]);
              negr_q <= div_signed && a[31];
              if (b == 32'd0) val_q <= div_rem ? a : 32'hFFFF_FFFF;
              else if (div_signed && a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
                val_q <= div_rem ? 32'd0 : 32'h8000_0000;
            end
            rvx_pkg::OP_EBREAK: begin
              st_q   <= rvx_pkg::ST_EBREAK;
              code_q <= a;
            end
            default: st_q <= rvx_pkg::ST_INVALID;
          endcase
        end
      end
      S_AMOD: begin
        // The reciprocal estimate of the quotient is at most one low, so the
        // first remainder is below twice the size and one subtract corrects it.
        if (cnt_q == 5'd0) rprod_q <= 64'(addr_q) * 64'(RECIP);
        if (cnt_q == 5'd1) rmod_q <= rest[AW:0];
        if (cnt_q == 5'd2) idx_q <= rmod_d[AW-1:0];
      end
      S_MEM: begin
        if (mem_act) idx_q <= idx_d;
        if (is_load && cnt_q != 5'd0) begin
          if (cnt_q == {2'b00, nbytes} && uop_q.f3 == rvx_pkg::F3_LH)
            val_q <= {{16{asm_val[15]}}, asm_val[15:0]};
          else val_q <= asm_val;
        end
      end
      S_DIV: begin
        if (rtry_d >= {1'b0, dvs_q}) begin
          rem_q <= rtry_d - {1'b0, dvs_q};
          dvd_q <= {dvd_q[30:0], 1'b1};
        end else begin
          rem_q <= rtry_d;
          dvd_q <= {dvd_q[30:0], 1'b0};
        end
      end
      S_DFIX: begin
        if (div_rem) val_q <= negr_q ? (32'd0 - rem_q[31:0]) : rem_q[31:0];
        else val_q <= negq_q ? (32'd0 - dvd_q) : dvd_q;
      end
      S_DONE: begin
        if (fire) begin
          this_pc_q     <= pc_q;
          next_pc_q     <= npc_q;
          reg_written_q <= wr_q && (uop_q.rd != 5'd0);
          reg_index_q   <= (wr_q && (uop_q.rd != 5'd0)) ? uop_q.rd : 5'd0;
          reg_value_q   <= (wr_q && (uop_q.rd != 5'd0)) ? val_q : 32'd0;
          status_q      <= st_q;
          halt_code_q   <= code_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) rf_q[uop_q.rd] <= val_q;
    if (uop_pop_o) begin
      a_raw_q <= rf_q[uop_i.rs1];
      b_raw_q <= rf_q[uop_i.rs2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) dmem_q[idx_q] <= mem_wd;
    mrd_q <= dmem_q[idx_q];
  end

  assign empty_o       = !out_vld_q;
  assign this_pc_o     = this_pc_q;
  assign next_pc_o     = next_pc_q;
  assign reg_written_o = reg_written_q;
  assign reg_index_o   = reg_index_q;
  assign reg_value_o   = reg_value_q;
  assign status_o      = status_q;
  assign halt_code_o   = halt_code_q;

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halted flag cleared");

  a_no_x0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> (uop_q.rd != 5'd0))
    else $error("write to x0");

  a_quiet_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !reg_written_q) |-> (reg_index_q == 5'd0 && reg_value_q == 32'd0))
    else $error("register fields set without a write");

  a_stop_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && status_q != rvx_pkg::ST_RUN) |-> !reg_written_q)
    else $error("register write on a stopping beat");

  a_halted_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && status_q == rvx_pkg::ST_HALTED) |-> (this_pc_q == next_pc_q))
    else $error("pc moved while halted");

endmodule

>>> hdl/rv32_subset_instruction_executor_unit.sv
// ALU, branch, jump and mul use the idle, execute and done states; a load or store of
// n bytes adds byte-wise memory accesses (one data memory byte port), after an address
// modulo step if the memory size is not a power of two; div, divu and rem use a radix-2
// divider. A two-beat decode queue in front lets new instructions arrive while one
// executes. Reset clears the register file, the halted flag and the queues and loads
// the pc with 0x80000000; data memory contents stay undefined until written.
module rv32_subset_instruction_executor_unit #(
  parameter int MEM_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [31:0] instruction_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] this_pc_o,
  output logic [31:0] next_pc_o,
  output logic        reg_written_o,
  output logic [4:0]  reg_index_o,
  output logic [31:0] reg_value_o,
  output logic [1:0]  status_o,
  output logic [31:0] halt_code_o
);

  rvx_pkg::uop_t uop;
  logic          uop_vld;
  logic          uop_pop;

  rvx_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .instruction_i (instruction_i),
    .full_o        (full),
    .uop_o         (uop),
    .uop_vld_o     (uop_vld),
    .uop_pop_i     (uop_pop)
  );

  rvx_exec #(
    .MEM_BYTES (MEM_BYTES)
  ) u_exec (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .uop_i         (uop),
    .uop_vld_i     (uop_vld),
    .uop_pop_o     (uop_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .this_pc_o     (this_pc_o),
    .next_pc_o     (next_pc_o),
    .reg_written_o (reg_written_o),
    .reg_index_o   (reg_index_o),
    .reg_value_o   (reg_value_o),
    .status_o      (status_o),
    .halt_code_o   (halt_code_o)
  );

endmodule

>>> sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MEM_BYTES = 65536;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    logic [31:0] this_pc;
    logic [31:0] next_pc;
    logic        written;
    logic [4:0]  index;
    logic [31:0] value;
    logic [1:0]  status;
    logic [31:0] halt_code;
  } exec_result_t;

  typedef struct {
    logic [31:0] word;
    bit          known;
    logic [31:0] value;
  } directed_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] instruction_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] this_pc_o, next_pc_o, reg_value_o, halt_code_o;
  logic        reg_written_o;
  logic [4:0]  reg_index_o;
  logic [1:0]  status_o;

  // Architectural state as the program sees it.
  logic [31:0] arch_regs [32];
  logic [31:0] arch_pc;
  bit          arch_halted;
  logic [7:0]  data_bytes [int];
  int          stored_addrs [$];

  exec_result_t pending_results [$];
  int           mismatches = 0;
  bit           send_burst = 1'b0;
  bit           recv_burst = 1'b0;

  rv32_subset_instruction_executor_unit #(.MEM_BYTES(MEM_BYTES)) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push          (push),
    .full          (full),
    .instruction_i (instruction_i),
    .empty         (empty),
    .pop           (pop),
    .this_pc_o     (this_pc_o),
    .next_pc_o     (next_pc_o),
    .reg_written_o (reg_written_o),
    .reg_index_o   (reg_index_o),
    .reg_value_o   (reg_value_o),
    .status_o      (status_o),
    .halt_code_o   (halt_code_o)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [2:0] f3, int rd, int rs1,
                                        int rs2);
    return {f7, 5'(rs2), 5'(rs1), f3, 5'(rd), rvx_pkg::OPC_OP};
  endfunction

  function automatic logic [31:0] enc_i(logic [6:0] opc, logic [2:0] f3, int rd, int rs1,
                                        logic [11:0] imm);
    return {imm, 5'(rs1), f3, 5'(rd), opc};
  endfunction

  function automatic logic [31:0] enc_s(logic [2:0] f3, int rs1, int rs2, logic [11:0] imm);
    return {imm[11:5], 5'(rs2), 5'(rs1), f3, imm[4:0], rvx_pkg::OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [2:0] f3, int rs1, int rs2, logic [12:0] imm);
    return {imm[12], imm[10:5], 5'(rs2), 5'(rs1), f3, imm[4:1], imm[11],
            rvx_pkg::OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(int rd, logic [20:0] imm);
    return {imm[20], imm[10:1], imm[11], imm[19:12], 5'(rd), rvx_pkg::OPC_JAL};
  endfunction

  function automatic int byte_slot(logic [31:0] addr, int k);
    logic [31:0] a;
    a = addr + 32'(k);
    return int'(a % MEM_BYTES);
  endfunction

  function automatic logic [31:0] load_bytes(logic [31:0] addr, int n);
    logic [31:0] v;
    v = '0;
    for (int k = 0; k < n; k++) begin
      v[8*k +: 8] = data_bytes.exists(byte_slot(addr, k)) ? data_bytes[byte_slot(addr, k)]
                                                         : 8'h00;
    end
    return v;
  endfunction

  function automatic void store_bytes(logic [31:0] addr, int n, logic [31:0] v);
    for (int k = 0; k < n; k++) data_bytes[byte_slot(addr, k)] = v[8*k +: 8];
    stored_addrs.push_back(byte_slot(addr, 0));
  endfunction

  // Executes one instruction against the architectural state and returns its beat.
  function automatic exec_result_t execute_insn(logic [31:0] w);
    exec_result_t r;
    logic [31:0] pc, npc, a, b, imm_i, imm_s, imm_b, imm_j, val, half;
    logic [6:0] opc, f7;
    logic [2:0] f3;
    logic [4:0] rd;
    bit wr, bad, take;
    pc = arch_pc;
    npc = pc + rvx_pkg::INSN_LEN;
    opc = w[6:0];
    rd = w[11:7];
    f3 = w[14:12];
    f7 = w[31:25];
    a = arch_regs[w[19:15]];
    b = arch_regs[w[24:20]];
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    val = '0;
    half = '0;
    wr = 0;
    bad = 0;
    take = 0;
    r = '0;
    if (arch_halted) begin
      r.this_pc = pc;
      r.next_pc = pc;
      r.status = rvx_pkg::ST_HALTED;
      return r;
    end
    case (opc)
      rvx_pkg::OPC_LUI: begin
        val = {w[31:12], 12'h000};
        wr = 1;
      end
      rvx_pkg::OPC_AUIPC: begin
        val = pc + {w[31:12], 12'h000};
        wr = 1;
      end
      rvx_pkg::OPC_JAL: begin
        val = pc + rvx_pkg::INSN_LEN;
        npc = pc + imm_j;
        wr = 1;
      end
      rvx_pkg::OPC_JALR: begin
        if (f3 != rvx_pkg::F3_JALR) bad = 1;
        else begin
          val = pc + rvx_pkg::INSN_LEN;
          npc = (a + imm_i) & ~32'd1;
          wr = 1;
        end
      end
      rvx_pkg::OPC_BRANCH: begin
        case (f3)
          rvx_pkg::F3_BEQ:  take = (a == b);
          rvx_pkg::F3_BNE:  take = (a != b);
          rvx_pkg::F3_BLT:  take = ($signed(a) < $signed(b));
          rvx_pkg::F3_BGE:  take = ($signed(a) >= $signed(b));
          rvx_pkg::F3_BLTU: take = (a < b);
          rvx_pkg::F3_BGEU: take = (a >= b);
          default: bad = 1;
        endcase
        if (take) npc = pc + imm_b;
      end
      rvx_pkg::OPC_LOAD: begin
        wr = 1;
        case (f3)
          rvx_pkg::F3_LW:  val = load_bytes(a + imm_i, 4);
          rvx_pkg::F3_LH: begin
            half = load_bytes(a + imm_i, 2);
            val = {{16{half[15]}}, half[15:0]};
          end
          rvx_pkg::F3_LBU: val = load_bytes(a + imm_i, 1);
          default: bad = 1;
        endcase
      end
      rvx_pkg::OPC_STORE: begin
        case (f3)
          rvx_pkg::F3_SB: store_bytes(a + imm_s, 1, b);
          rvx_pkg::F3_SH: store_bytes(a + imm_s, 2, b);
          rvx_pkg::F3_SW: store_bytes(a + imm_s, 4, b);
          default: bad = 1;
        endcase
      end
      rvx_pkg::OPC_OPIMM: begin
        wr = 1;
        case (f3)
          rvx_pkg::F3_ADD:  val = a + imm_i;
          rvx_pkg::F3_SLTU: val = 32'(a < imm_i);
          rvx_pkg::F3_XOR:  val = a ^ imm_i;
          rvx_pkg::F3_OR:   val = a | imm_i;
          rvx_pkg::F3_AND:  val = a & imm_i;
          rvx_pkg::F3_SLL: begin
            if (f7 == rvx_pkg::F7_BASE) val = a << w[24:20];
            else bad = 1;
          end
          rvx_pkg::F3_SR: begin
            if (f7 == rvx_pkg::F7_BASE) val = a >> w[24:20];
            else if (f7 == rvx_pkg::F7_ALT) val = $signed(a) >>> w[24:20];
            else bad = 1;
          end
          default: bad = 1;
        endcase
      end
      rvx_pkg::OPC_OP: begin
        wr = 1;
        if (f7 == rvx_pkg::F7_BASE && f3 == rvx_pkg::F3_ADD) val = a + b;
        else if (f7 == rvx_pkg::F7_ALT && f3 == rvx_pkg::F3_ADD) val = a - b;
        else if (f7 == rvx_pkg::F7_BASE && f3 == rvx_pkg::F3_SLL) val = a << b[4:0];
        else if (f7 == rvx_pkg::F7_BASE && f3 == rvx_pkg::F3_SLTU) val = 32'(a < b);
        else if (f7 == rvx_pkg::F7_BASE && f3 == rvx_pkg::F3_XOR) val = a ^ b;
        else if (f7 == rvx_pkg::F7_BASE && f3 == rvx_pkg::F3_OR) val = a | b;
        else if (f7 == rvx_pkg::F7_BASE && f3 == rvx_pkg::F3_AND) val = a & b;
        else if (f7 == rvx_pkg::F7_ALT && f3 == rvx_pkg::F3_SR) val = $signed(a) >>> b[4:0];
        else if (f7 == rvx_pkg::F7_MULDIV && f3 == rvx_pkg::F3_MUL) val = a * b;
        else if (f7 == rvx_pkg::F7_MULDIV &&
                 (f3 == rvx_pkg::F3_DIV || f3 == rvx_pkg::F3_REM)) begin
          if (b == 0) val = (f3 == rvx_pkg::F3_REM) ? a : 32'hFFFF_FFFF;
          else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
            val = (f3 == rvx_pkg::F3_REM) ? 32'h0 : 32'h8000_0000;
          else if (f3 == rvx_pkg::F3_REM) val = $signed(a) % $signed(b);
          else val = $signed(a) / $signed(b);
        end
        else if (f7 == rvx_pkg::F7_MULDIV && f3 == rvx_pkg::F3_DIVU)
          val = (b == 0) ? 32'hFFFF_FFFF : a / b;
        else bad = 1;
      end
      rvx_pkg::OPC_SYSTEM: begin
        if (w == rvx_pkg::EBREAK_WORD) begin
          r.status = rvx_pkg::ST_EBREAK;
          r.halt_code = arch_regs[rvx_pkg::REG_A0];
          arch_halted = 1;
        end else bad = 1;
      end
      default: bad = 1;
    endcase
    if (bad) begin
      wr = 0;
      r.status = rvx_pkg::ST_INVALID;
      npc = pc + rvx_pkg::INSN_LEN;
      arch_halted = 1;
    end
    if (wr && rd != 0) begin
      arch_regs[rd] = val;
      r.written = 1;
      r.index = rd;
      r.value = val;
    end
    arch_pc = npc;
    r.this_pc = pc;
    r.next_pc = npc;
    return r;
  endfunction

  function automatic int draw_wait(bit burst);
    return burst ? 0 : int'($urandom_range(0, 17));
  endfunction

  // Builds a load whose base register and offset reach bytes already stored; returns 0 if none.
  function automatic logic [31:0] gen_load();
    int target, base, n;
    logic [15:0] d;
    logic [2:0] f3;
    bit ok;
    if (stored_addrs.size() == 0) return 32'h0;
    for (int t = 0; t < 8; t++) begin
      target = stored_addrs[$urandom_range(0, stored_addrs.size() - 1)];
      base = (t == 7) ? 0 : int'($urandom_range(0, 31));
      d = 16'(target) - arch_regs[base][15:0];
      if (d >= 16'd2048 && d < 16'hF800) continue;
      case ($urandom_range(0, 2))
        0: begin f3 = rvx_pkg::F3_LW; n = 4; end
        1: begin f3 = rvx_pkg::F3_LH; n = 2; end
        default: begin f3 = rvx_pkg::F3_LBU; n = 1; end
      endcase
      ok = 1;
      for (int k = 0; k < n; k++) if (!data_bytes.exists((target + k) % MEM_BYTES)) ok = 0;
      if (ok) return enc_i(rvx_pkg::OPC_LOAD, f3, $urandom_range(0, 31), base, d[11:0]);
    end
    return 32'h0;
  endfunction

  function automatic logic [31:0] gen_random_insn();
    logic [2:0] br_f3 [6] = '{rvx_pkg::F3_BEQ, rvx_pkg::F3_BNE, rvx_pkg::F3_BLT,
                              rvx_pkg::F3_BGE, rvx_pkg::F3_BLTU, rvx_pkg::F3_BGEU};
    logic [2:0] im_f3 [7] = '{rvx_pkg::F3_ADD, rvx_pkg::F3_SLTU, rvx_pkg::F3_XOR,
                              rvx_pkg::F3_OR, rvx_pkg::F3_AND, rvx_pkg::F3_SLL,
                              rvx_pkg::F3_SR};
    logic [6:0] op_f7 [12] = '{rvx_pkg::F7_BASE, rvx_pkg::F7_ALT, rvx_pkg::F7_BASE,
                               rvx_pkg::F7_BASE, rvx_pkg::F7_BASE, rvx_pkg::F7_BASE,
                               rvx_pkg::F7_BASE, rvx_pkg::F7_ALT, rvx_pkg::F7_MULDIV,
                               rvx_pkg::F7_MULDIV, rvx_pkg::F7_MULDIV, rvx_pkg::F7_MULDIV};
    logic [2:0] op_f3 [12] = '{rvx_pkg::F3_ADD, rvx_pkg::F3_ADD, rvx_pkg::F3_SLL,
                               rvx_pkg::F3_SLTU, rvx_pkg::F3_XOR, rvx_pkg::F3_OR,
                               rvx_pkg::F3_AND, rvx_pkg::F3_SR, rvx_pkg::F3_MUL,
                               rvx_pkg::F3_DIV, rvx_pkg::F3_DIVU, rvx_pkg::F3_REM};
    logic [31:0] w;
    logic [2:0] f3;
    int sel, pick, rd, rs1, rs2;
    sel = $urandom_range(0, 99);
    rd = $urandom_range(0, 31);
    rs1 = $urandom_range(0, 31);
    rs2 = $urandom_range(0, 31);
    w = $urandom;
    if (sel < 8) return {w[31:12], 5'(rd), rvx_pkg::OPC_LUI};
    if (sel < 12) return {w[31:12], 5'(rd), rvx_pkg::OPC_AUIPC};
    if (sel < 16) return enc_j(rd, w[20:0]);
    if (sel < 20) return enc_i(rvx_pkg::OPC_JALR, rvx_pkg::F3_JALR, rd, rs1, w[11:0]);
    if (sel < 32) return enc_b(br_f3[$urandom_range(0, 5)], rs1, rs2, w[12:0]);
    if (sel < 44) begin
      w = gen_load();
      if (w != 0) return w;
      return enc_i(rvx_pkg::OPC_OPIMM, rvx_pkg::F3_ADD, rd, rs1, 12'($urandom));
    end
    if (sel < 56) begin
      case ($urandom_range(0, 2))
        0: f3 = rvx_pkg::F3_SB;
        1: f3 = rvx_pkg::F3_SH;
        default: f3 = rvx_pkg::F3_SW;
      endcase
      return enc_s(f3, rs1, rs2, w[11:0]);
    end
    if (sel < 74) begin
      f3 = im_f3[$urandom_range(0, 6)];
      if (f3 == rvx_pkg::F3_SLL) w[31:25] = rvx_pkg::F7_BASE;
      if (f3 == rvx_pkg::F3_SR) w[31:25] = w[0] ? rvx_pkg::F7_ALT : rvx_pkg::F7_BASE;
      return enc_i(rvx_pkg::OPC_OPIMM, f3, rd, rs1, w[31:20]);
    end
    pick = $urandom_range(0, 11);
    return enc_r(op_f7[pick], op_f3[pick], rd, rs1, rs2);
  endfunction

  task automatic send_insn(logic [31:0] w, bit known, logic [31:0] value);
    int gap;
    exec_result_t r;
    gap = draw_wait(send_burst);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1'b1;
    instruction_i <= w;
    do @(posedge clk_i); while (full);
    r = execute_insn(w);
    if (known) r.value = value;
    pending_results.push_back(r);
    @(negedge clk_i);
  endtask

  // Waits until the block has drained before touching the start address.
  task automatic write_start(logic [31:0] addr);
    push <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= addr;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    arch_pc = addr;
  endtask

  initial begin
    directed_row_t rows [$];
    logic [31:0] tail_words [7];
    logic [31:0] phase_starts [4];
    for (int i = 0; i < 32; i++) arch_regs[i] = '0;
    arch_pc = rvx_pkg::RESET_PC;
    arch_halted = 0;
    rows = '{
      '{{20'h80000, 5'd1, rvx_pkg::OPC_LUI}, 1, 32'h8000_0000},
      '{enc_i(rvx_pkg::OPC_OPIMM, rvx_pkg::F3_ADD, 2, 0, 12'hFFF), 1, 32'hFFFF_FFFF},
      '{enc_r(rvx_pkg::F7_MULDIV, rvx_pkg::F3_DIV, 3, 1, 2), 1, 32'h8000_0000},
      '{enc_r(rvx_pkg::F7_MULDIV, rvx_pkg::F3_REM, 4, 1, 2), 1, 32'h0},
      '{enc_r(rvx_pkg::F7_MULDIV, rvx_pkg::F3_DIV, 5, 2, 0), 1, 32'hFFFF_FFFF},
      '{enc_r(rvx_pkg::F7_MULDIV, rvx_pkg::F3_DIVU, 6, 1, 0), 1, 32'hFFFF_FFFF},
      '{enc_r(rvx_pkg::F7_MULDIV, rvx_pkg::F3_REM, 7, 1, 0), 1, 32'h8000_0000},
      '{enc_r(rvx_pkg::F7_ALT, rvx_pkg::F3_SR, 8, 1, 2), 1, 32'hFFFF_FFFF},
      '{enc_i(rvx_pkg::OPC_OPIMM, rvx_pkg::F3_SR, 9, 1, {rvx_pkg::F7_ALT, 5'd4}), 1,
        32'hF800_0000},
      '{enc_i(rvx_pkg::OPC_OPIMM, rvx_pkg::F3_ADD, 10, 0, 12'h7FF), 1, 32'h0000_07FF},
      '{enc_s(rvx_pkg::F3_SW, 0, 1, 12'hFFC), 0, 32'h0},
      '{enc_s(rvx_pkg::F3_SH, 0, 2, 12'h7FE), 0, 32'h0},
      '{enc_i(rvx_pkg::OPC_LOAD, rvx_pkg::F3_LH, 11, 0, 12'h7FE), 1, 32'hFFFF_FFFF},
      '{enc_i(rvx_pkg::OPC_LOAD, rvx_pkg::F3_LBU, 12, 0, 12'hFFF), 1, 32'h0000_0080},
      '{enc_i(rvx_pkg::OPC_LOAD, rvx_pkg::F3_LW, 13, 0, 12'hFFC), 1, 32'h8000_0000},
      '{enc_s(rvx_pkg::F3_SW, 0, 10, 12'hFFE), 0, 32'h0},
      '{enc_i(rvx_pkg::OPC_LOAD, rvx_pkg::F3_LW, 14, 0, 12'hFFE), 1, 32'h0000_07FF},
      '{enc_b(rvx_pkg::F3_BLT, 1, 10, 13'h0008), 0, 32'h0},
      '{enc_b(rvx_pkg::F3_BGEU, 1, 10, 13'h1FF0), 0, 32'h0},
      '{enc_i(rvx_pkg::OPC_OPIMM, rvx_pkg::F3_SLTU, 15, 10, 12'hFFF), 1, 32'h1},
      '{enc_r(rvx_pkg::F7_BASE, rvx_pkg::F3_ADD, 0, 1, 1), 1, 32'h0},
      '{enc_j(16, 21'h100000), 0, 32'h0},
      '{enc_i(rvx_pkg::OPC_JALR, rvx_pkg::F3_JALR, 17, 2, 12'h7FF), 0, 32'h0},
      '{{20'hFFFFF, 5'd18, rvx_pkg::OPC_AUIPC}, 0, 32'h0},
      '{enc_r(rvx_pkg::F7_BASE, rvx_pkg::F3_SLL, 19, 10, 2), 1, 32'h8000_0000},
      '{enc_r(rvx_pkg::F7_MULDIV, rvx_pkg::F3_MUL, 20, 2, 2), 1, 32'h1}
    };
    phase_starts = '{32'hFFFF_FFFF, rvx_pkg::RESET_PC, $urandom, $urandom};
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_start(32'h0);
    foreach (rows[i]) send_insn(rows[i].word, rows[i].known, rows[i].value);
    for (int p = 0; p < 4; p++) begin
      write_start(phase_starts[p]);
      for (int n = 0; n < 250; n++) begin
        if ($urandom_range(0, 39) == 0) send_burst = ~send_burst;
        send_insn(gen_random_insn(), 0, 32'h0);
      end
    end
    // The block halts for good, so the halting cases close the run.
    tail_words = '{rvx_pkg::EBREAK_WORD, enc_i(rvx_pkg::OPC_LOAD, 3'd0, 1, 0, 12'h0),
                   enc_i(rvx_pkg::OPC_LOAD, 3'd5, 1, 0, 12'h0),
                   enc_r(rvx_pkg::F7_BASE, 3'd2, 1, 2, 3),
                   enc_r(rvx_pkg::F7_BASE, rvx_pkg::F3_SR, 1, 2, 3),
                   {25'h0, rvx_pkg::OPC_SYSTEM}, 32'hFFFF_FFFF};
    send_insn(tail_words[$urandom_range(0, 6)], 0, 32'h0);
    repeat (4) send_insn($urandom, 0, 32'h0);
    push <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    exec_result_t got, want;
    int gap;
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = ~recv_burst;
      gap = draw_wait(recv_burst);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty !== 1'b0);
      got = '{this_pc_o, next_pc_o, reg_written_o, reg_index_o, reg_value_o, status_o,
              halt_code_o};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
      @(negedge clk_i);
    end
  end

endmodule

>>> filelist.f
hdl/rvx_pkg.sv
hdl/rvx_decode.sv
hdl/rvx_exec.sv
hdl/rv32_subset_instruction_executor_unit.sv
sim/tb_top.sv
